// File: design/ffbm_pkg.sv
// Shared types and constants of the first-fit block map allocator.
// Used by every module of the allocator but ffbm_ram; depends on nothing.
package ffbm_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int BLK_SHIFT   = 12;
    localparam int CNT_W       = 11;
    localparam int NEED_W      = 32 - BLK_SHIFT + 1;
    localparam int REL_W       = 32 - BLK_SHIFT;
    localparam int THIRD_MUL   = 2731;
    localparam int THIRD_SHIFT = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd1024;

    typedef logic [CNT_W-1:0]  t_idx;
    typedef logic [NEED_W-1:0] t_need;

    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_USED = 2'd1,
        MARK_END  = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_RUN = 2'd1,
        ST_ZERO   = 2'd2,
        ST_NO_END = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic {
        CFG_TOTAL_BLOCKS = 1'b0,
        CFG_MEM_BASE     = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REJECT = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_status   status;
        t_idx      start;
        t_idx      limit;
        t_need     need;
    } t_cmd;

    typedef struct packed {
        logic [31:0] mem_base;
        logic        clear_req;
    } t_cfg;

endpackage

// File: design/ffbm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffbm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/ffbm_fifo.sv
// Short command queue between the front and back parts of the allocator.
// Depends on ffbm_pkg for the command type and the queue depth.
module ffbm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  ffbm_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_pop,
    output ffbm_pkg::t_cmd  o_cmd
);
    import ffbm_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule

// File: design/ffbm_front.sv
// Front part of the allocator: configuration registers, heap bounds and request classification.
// Depends on ffbm_pkg; feeds commands into ffbm_fifo.
module ffbm_front #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  ffbm_pkg::t_cfg_reg  i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  logic                i_heap_select,
    input  logic [31:0]         i_request_size,
    input  logic [31:0]         i_free_address,
    input  logic                i_clearing,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output ffbm_pkg::t_cmd      o_cmd,
    output ffbm_pkg::t_cfg      o_cfg
);
    import ffbm_pkg::*;

    t_idx        r_total, n_total;
    logic [31:0] r_mem_base, n_mem_base;
    t_idx        r_n, r_third, r_kcnt, r_ucnt;
    logic [31:0] r_ubase;
    t_idx        clamp;

    logic        r_in_valid, n_in_valid;
    logic        r_req, r_heap;
    logic [31:0] r_size, r_addr;
    logic        accept;

    t_idx        first, count;
    t_need       need;
    logic [31:0] heap_base, diff;
    logic [REL_W-1:0] rel;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (!r_in_valid || i_cmd_ready) && !i_clearing && !i_cfg_we;
    assign o_cmd_valid = r_in_valid;

    assign o_cfg.mem_base  = r_mem_base;
    assign o_cfg.clear_req = i_cfg_we && (i_cfg_index == CFG_TOTAL_BLOCKS);

    always_comb begin
        n_total    = r_total;
        n_mem_base = r_mem_base;
        if (i_cfg_we && i_cfg_index == CFG_TOTAL_BLOCKS) begin
            n_total = i_cfg_data[CNT_W-1:0];
        end
        if (i_cfg_we && i_cfg_index == CFG_MEM_BASE) begin
            n_mem_base = i_cfg_data;
        end
        clamp = (32'(r_total) < MAX_BLOCKS) ? r_total : CNT_W'(MAX_BLOCKS);
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (r_in_valid && i_cmd_ready) begin
            n_in_valid = 1'b0;
        end
    end

    // The kernel heap takes the remainder of the split, the user heap twice one third.
    always_comb begin
        first     = r_heap ? r_kcnt : '0;
        count     = r_heap ? r_ucnt : r_kcnt;
        need      = NEED_W'((33'(r_size) + 33'(BLOCK_BYTES - 1)) >> BLK_SHIFT);
        heap_base = r_heap ? r_ubase : r_mem_base;
        diff      = r_addr - heap_base;
        rel       = diff[31:BLK_SHIFT];

        o_cmd.kind   = CMD_REJECT;
        o_cmd.status = ST_OK;
        o_cmd.start  = first;
        o_cmd.limit  = first + count;
        o_cmd.need   = need;
        if (r_req == REQ_ALLOC) begin
            if (r_size == '0) begin
                o_cmd.status = ST_ZERO;
            end else if (need > NEED_W'(count)) begin
                o_cmd.status = ST_NO_RUN;
            end else begin
                o_cmd.kind = CMD_ALLOC;
            end
        end else begin
            if (rel >= REL_W'(count)) begin
                o_cmd.status = ST_NO_END;
            end else begin
                o_cmd.kind  = CMD_FREE;
                o_cmd.start = first + rel[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_mem_base <= '0;
            r_in_valid <= 1'b0;
        end else begin
            r_total    <= n_total;
            r_mem_base <= n_mem_base;
            r_in_valid <= n_in_valid;
        end
        r_n     <= clamp;
        r_third <= CNT_W'((23'(clamp) * 23'(THIRD_MUL)) >> THIRD_SHIFT);
        r_kcnt  <= r_n - (r_third << 1);
        r_ucnt  <= r_third << 1;
        r_ubase <= r_mem_base + (32'(r_kcnt) << BLK_SHIFT);
        if (accept) begin
            r_req  <= i_req_type;
            r_heap <= i_heap_select;
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
    end
endmodule

// File: design/ffbm_back.sv
// Back part of the allocator: owns the block map and runs the scan, mark, walk and clear passes.
// Depends on ffbm_pkg and ffbm_ram.
module ffbm_back #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffbm_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  ffbm_pkg::t_cmd    i_cmd,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ffbm_pkg::t_status o_status,
    output logic [31:0]       o_block_address
);
    import ffbm_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MARK  = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    t_idx        r_rd_idx, n_rd_idx;
    logic        r_dv, n_dv;
    t_idx        r_didx, n_didx;
    t_idx        r_run, n_run;
    t_idx        r_wr_idx, n_wr_idx;
    t_idx        r_start, n_start;
    t_idx        r_last, n_last;
    t_status     r_res_status, n_res_status;
    logic [31:0] r_res_addr, n_res_addr;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic        r_out_valid, n_out_valid;
    t_status     r_out_status, n_out_status;
    logic [31:0] r_out_addr, n_out_addr;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [1:0]    ram_wdata, ram_rdata;
    logic          issue;
    t_idx          run_n;

    ffbm_ram #(.WIDTH(2), .DEPTH(MAX_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_block_address = r_out_addr;
    assign issue           = (r_rd_idx < r_cmd.limit);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_rd_idx     = r_rd_idx;
        n_dv         = r_dv;
        n_didx       = r_didx;
        n_run        = r_run;
        n_wr_idx     = r_wr_idx;
        n_start      = r_start;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_clr_idx    = r_clr_idx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = MARK_FREE;
        ram_raddr    = IW'(r_rd_idx);
        o_cmd_ready  = 1'b0;
        run_n        = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_rd_idx = i_cmd.start;
                    n_dv     = 1'b0;
                    n_run    = '0;
                    unique case (i_cmd.kind)
                        CMD_ALLOC: n_state = S_SCAN;
                        CMD_FREE:  n_state = S_WALK;
                        default: begin
                            n_res_status = i_cmd.status;
                            n_res_addr   = '0;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_dv   = issue;
                n_didx = r_rd_idx;
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_dv) begin
                    run_n = (ram_rdata == MARK_FREE) ? r_run + 1'b1 : '0;
                    n_run = run_n;
                    if (NEED_W'(run_n) == r_cmd.need) begin
                        n_start  = r_didx + 1'b1 - run_n;
                        n_wr_idx = r_didx + 1'b1 - run_n;
                        n_last   = r_didx;
                        n_dv     = 1'b0;
                        n_state  = S_MARK;
                    end else if (r_didx == r_cmd.limit - 1'b1) begin
                        n_res_status = ST_NO_RUN;
                        n_res_addr   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_wr_idx);
                ram_wdata = (r_wr_idx == r_last) ? MARK_END : MARK_USED;
                n_wr_idx  = r_wr_idx + 1'b1;
                if (r_wr_idx == r_last) begin
                    n_res_status = ST_OK;
                    n_res_addr   = i_cfg.mem_base + (32'(r_start) << BLK_SHIFT);
                    n_state      = S_DONE;
                end
            end
            S_WALK: begin
                n_dv   = issue;
                n_didx = r_rd_idx;
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(r_didx);
                    ram_wdata = MARK_FREE;
                    if (ram_rdata == MARK_END) begin
                        n_res_status = ST_OK;
                        n_res_addr   = '0;
                        n_dv         = 1'b0;
                        n_state      = S_DONE;
                    end else if (r_didx == r_cmd.limit - 1'b1) begin
                        n_res_status = ST_NO_END;
                        n_res_addr   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Resizing the map starts a fresh clearing pass.
        if (i_cfg.clear_req) begin
            n_state   = S_CLEAR;
            n_clr_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_rd_idx     <= n_rd_idx;
        r_didx       <= n_didx;
        r_run        <= n_run;
        r_wr_idx     <= n_wr_idx;
        r_start      <= n_start;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end
endmodule

// File: design/first_fit_block_map_allocator_core.sv
// Top level of the first-fit block map allocator.
// Depends on ffbm_pkg, ffbm_front, ffbm_fifo and ffbm_back (with ffbm_ram).
//
// Requests arrive as words on the input valid/ready channel: an allocate takes a heap
// and a byte size, a free takes a heap and a byte address. Each request gives exactly
// one result word on the output valid/ready channel, in request order: a status and,
// for a successful allocate, the byte address of the run.
// The front registers and classifies a request and queues it for the back,
// which walks the block map held in a RAM, one mark per cycle with registered reads.
// An allocate scans the map for a free run and then marks it; a free walks the map
// from the named block to the run end; rejected requests go straight to a result.
// The map walk bounds the throughput.
// After reset, and after every write of total_blocks, a clearing pass sets all MAX_BLOCKS
// marks free; input ready stays low meanwhile, while configuration
// writes are still taken. Registers are written through the plain write port.
// When the receiver stalls, the result waits in the output register; the front keeps
// accepting until the queue and the front register are full, then input ready drops.
module first_fit_block_map_allocator_core #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  ffbm_pkg::t_cfg_reg  i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  logic                i_heap_select,
    input  logic [31:0]         i_request_size,
    input  logic [31:0]         i_free_address,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [31:0]         o_block_address
);
    import ffbm_pkg::*;

    t_cmd    front_cmd, queue_cmd;
    t_cfg    cfg;
    logic    front_valid, queue_ready;
    logic    queue_valid, back_ready;
    logic    clearing;
    t_status status;

    ffbm_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_heap_select  (i_heap_select),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_clearing     (clearing),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (queue_ready),
        .o_cmd          (front_cmd),
        .o_cfg          (cfg)
    );

    ffbm_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (back_ready),
        .o_cmd   (queue_cmd)
    );

    ffbm_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd_valid     (queue_valid),
        .o_cmd_ready     (back_ready),
        .i_cmd           (queue_cmd),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (status),
        .o_block_address (o_block_address)
    );

    assign o_status = status;
endmodule

// File: test/tb_first_fit_block_map_allocator_core.sv
// Self-checking testbench for first_fit_block_map_allocator_core, with an allocation ledger
// that predicts each result word from its own copy of the block map and the registers.
// Depends on ffbm_pkg and the allocator RTL; needs nothing else.

class alloc_ledger #(parameter int MAP_BLOCKS = 1024);
    typedef struct packed {
        ffbm_pkg::t_status status;
        logic [31:0]       addr;
    } t_result;

    ffbm_pkg::t_mark marks[MAP_BLOCKS];
    logic [10:0]     total;
    logic [31:0]     base;
    t_result         awaited[$];
    int              errors;
    int              last_start;

    function new();
        total  = ffbm_pkg::TOTAL_RESET;
        base   = '0;
        errors = 0;
        clear_marks();
    endfunction

    function void clear_marks();
        foreach (marks[i]) marks[i] = ffbm_pkg::MARK_FREE;
    endfunction

    function void write_config(ffbm_pkg::t_cfg_reg idx, logic [31:0] value);
        if (idx == ffbm_pkg::CFG_TOTAL_BLOCKS) begin
            total = value[10:0];
            clear_marks();
        end else begin
            base = value;
        end
    endfunction

    function void heap_span(logic heap, output int unsigned first, output int unsigned count);
        int unsigned n, kb;
        n  = (total < MAP_BLOCKS) ? int'(total) : MAP_BLOCKS;
        kb = n / 3 + n % 3;
        first = heap ? kb : 0;
        count = heap ? (n / 3) * 2 : kb;
    endfunction

    function logic [31:0] block_byte(int unsigned idx);
        return base + (32'(idx) << ffbm_pkg::BLK_SHIFT);
    endfunction

    function void note_request(ffbm_pkg::t_req req, logic heap, logic [31:0] size,
                               logic [31:0] addr);
        int unsigned first, count, run, idx;
        logic [32:0] need;
        logic [31:0] rel;
        t_result     res;
        res.status = ffbm_pkg::ST_OK;
        res.addr   = '0;
        last_start = -1;
        heap_span(heap, first, count);
        if (req == ffbm_pkg::REQ_ALLOC) begin
            if (size == 0) begin
                res.status = ffbm_pkg::ST_ZERO;
            end else begin
                need = ({1'b0, size} + 33'(ffbm_pkg::BLOCK_BYTES - 1)) >> ffbm_pkg::BLK_SHIFT;
                res.status = ffbm_pkg::ST_NO_RUN;
                run = 0;
                for (idx = first; idx < first + count && last_start < 0; idx++) begin
                    run = (marks[idx] == ffbm_pkg::MARK_FREE) ? run + 1 : 0;
                    if (33'(run) == need) begin
                        last_start = idx + 1 - run;
                        for (int k = last_start; k < idx; k++) marks[k] = ffbm_pkg::MARK_USED;
                        marks[idx] = ffbm_pkg::MARK_END;
                        res.status = ffbm_pkg::ST_OK;
                        res.addr   = block_byte(last_start);
                    end
                end
            end
        end else begin
            // The walk clears every mark it passes, the run end included.
            rel = (addr - block_byte(first)) >> ffbm_pkg::BLK_SHIFT;
            res.status = ffbm_pkg::ST_NO_END;
            if (rel < count) begin
                for (idx = first + rel; idx < first + count && res.status != ffbm_pkg::ST_OK;
                     idx++) begin
                    if (marks[idx] == ffbm_pkg::MARK_END) res.status = ffbm_pkg::ST_OK;
                    marks[idx] = ffbm_pkg::MARK_FREE;
                end
            end
        end
        awaited.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] addr);
        t_result want;
        if (awaited.size() == 0) begin
            $display("%0t: result word with nothing awaited: status %0d, address %h",
                     $time, status, addr);
            errors++;
        end else begin
            want = awaited.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
                errors++;
            end
            if (addr !== want.addr) begin
                $display("%0t: block address expected %h, actual %h", $time, want.addr, addr);
                errors++;
            end
        end
    endfunction
endclass

module tb_first_fit_block_map_allocator_core;
    import ffbm_pkg::*;

    localparam int MAP_BLOCKS  = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * MAP_BLOCKS + 64;
    localparam int N_PHASES    = 8;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    t_cfg_reg    i_cfg_index    = CFG_TOTAL_BLOCKS;
    logic [31:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        i_req_type     = 1'b0;
    logic        i_heap_select  = 1'b0;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_free_address = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_block_address;

    alloc_ledger #(MAP_BLOCKS) ledger;

    bit   calm = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    logic live_heap[$];
    int   live_idx[$];

    always #2 i_clk = ~i_clk;

    first_fit_block_map_allocator_core #(
        .MAX_BLOCKS(MAP_BLOCKS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_heap_select  (i_heap_select),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_block_address(o_block_address)
    );

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(1, 7) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_result(o_status, o_block_address);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_first_fit_block_map_allocator_core failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [31:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_data  = $urandom;
        ledger.write_config(idx, value);
        if (idx == CFG_TOTAL_BLOCKS) begin
            live_heap.delete();
            live_idx.delete();
        end
    endtask

    task automatic send_request(t_req req, logic heap, logic [31:0] size, logic [31:0] addr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_req_type     = req;
        i_heap_select  = heap;
        i_request_size = size;
        i_free_address = addr;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        ledger.note_request(req, heap, size, addr);
        if (req == REQ_ALLOC && ledger.last_start >= 0) begin
            live_heap.push_back(heap);
            live_idx.push_back(ledger.last_start);
        end
        @(negedge i_clk);
    endtask

    task automatic alloc_req(logic heap, logic [31:0] size);
        send_request(REQ_ALLOC, heap, size, $urandom);
    endtask

    task automatic free_req(logic heap, logic [31:0] addr);
        send_request(REQ_FREE, heap, $urandom, addr);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (ledger.awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_item();
        int          r, j;
        int unsigned first, count;
        logic        h;
        logic [31:0] off;
        r = $urandom_range(0, 99);
        h = 1'($urandom_range(0, 1));
        if (live_idx.size() != 0 && r < 40) begin
            j   = $urandom_range(0, live_idx.size() - 1);
            off = (r < 6) ? $urandom_range(1, BLOCK_BYTES - 1) : 0;
            free_req(live_heap[j], ledger.block_byte(live_idx[j]) + off);
            live_heap.delete(j);
            live_idx.delete(j);
        end else if (r < 78) begin
            if (r[0]) alloc_req(h, $urandom_range(1, 6 * BLOCK_BYTES));
            else alloc_req(h, $urandom_range(1, 6) * BLOCK_BYTES);
        end else if (r < 82) begin
            alloc_req(h, 0);
        end else if (r < 87) begin
            alloc_req(h, $urandom);
        end else if (r < 92) begin
            free_req(h, $urandom);
        end else if (r < 97 && live_idx.size() != 0) begin
            // At or just after the start of a live run, named with its own heap or the other one.
            j = $urandom_range(0, live_idx.size() - 1);
            free_req(live_heap[j] ^ r[0], ledger.block_byte(live_idx[j] + $urandom_range(0, 2)));
        end else begin
            ledger.heap_span(h, first, count);
            free_req(h, ledger.block_byte(first + $urandom_range(0, count)));
        end
    endtask

    initial begin
        int          p, k;
        logic [10:0] totals[N_PHASES];
        logic [31:0] bases[N_PHASES];
        int          items[N_PHASES];
        totals = '{11'd2047, 11'd0, 11'd1, 11'd5, 11'd30, 11'd100, 11'd3, 11'd64};
        bases  = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_E000, $urandom, 32'h1000_0000,
                   $urandom, $urandom};
        items  = '{60, 10, 20, 45, 60, 60, 30, 80};
        ledger = new();
        i_cfg_data = $urandom;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        alloc_req(1'b0, 32'd0);
        alloc_req(1'b0, 32'd1);
        alloc_req(1'b0, 32'd4096);
        alloc_req(1'b0, 32'd4097);
        alloc_req(1'b1, 32'hFFFF_FFFF);
        alloc_req(1'b1, 32'd682 * BLOCK_BYTES);
        alloc_req(1'b1, 32'd1);
        free_req(1'b1, 32'd342 * BLOCK_BYTES);
        alloc_req(1'b0, 32'd339 * BLOCK_BYTES);
        alloc_req(1'b0, 32'd338 * BLOCK_BYTES);
        free_req(1'b0, 32'h0000_2123);
        free_req(1'b0, 32'h0000_1000);
        free_req(1'b0, 32'h0000_1000);
        free_req(1'b0, 32'h0000_2000);
        free_req(1'b1, 32'h0);
        free_req(1'b0, 32'd342 * BLOCK_BYTES);
        alloc_req(1'b1, 32'd3 * BLOCK_BYTES);
        free_req(1'b1, 32'd343 * BLOCK_BYTES);
        alloc_req(1'b1, 32'd2 * BLOCK_BYTES);
        free_req(1'b1, 32'hFFFF_FFFF);
        free_req(1'b0, 32'h0);
        alloc_req(1'b0, 32'hFFFF_F001);
        wait_drained();

        for (p = 0; p < N_PHASES; p++) begin
            calm = (p == N_PHASES - 1);
            write_reg(CFG_TOTAL_BLOCKS, {21'($urandom_range(0, 2097151)), totals[p]});
            write_reg(CFG_MEM_BASE, bases[p]);
            for (k = 0; k < items[p]; k++) begin
                // A base move keeps the marks, so live runs are then freed at new addresses.
                if (p == 5 && k == items[p] / 2) begin
                    wait_drained();
                    write_reg(CFG_MEM_BASE, $urandom);
                end
                random_item();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
            $display("tb_first_fit_block_map_allocator_core passed");
        end else begin
            $display("tb_first_fit_block_map_allocator_core failed");
        end
        $finish;
    end

endmodule
